FILE: sv/perimeter_force_accumulator_defines.svh
// Assertion macros used by the back end of the perimeter force accumulator RTL.
`ifndef PERIMETER_FORCE_ACCUMULATOR_DEFINES_SVH
`define PERIMETER_FORCE_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, checked on clk, off during rst.
`define PFA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, off during rst.
`define PFA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/pfa_pkg.sv
// Shared constants, types and fixed-point helpers of the perimeter force accumulator.
`default_nettype none
package pfa_pkg;

  localparam int FACE_COUNT = 1024;
  localparam int FIDX_W     = (FACE_COUNT > 1) ? $clog2(FACE_COUNT) : 1;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic signed [63:0] Q_MAX64 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] Q_MIN64 = 64'shFFFF_FFFF_8000_0000;

  // One classified half-edge request handed from front to back.
  typedef struct packed {
    logic               active;
    logic               last;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [31:0] g1;
    logic signed [31:0] l1;
    logic signed [31:0] g2;
    logic signed [31:0] l2;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
  } edge_job_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] v;
  } sat32_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
  } result_t;

  function automatic sat32_t clamp32(input logic signed [63:0] t);
    sat32_t r;
    r.sat = 1'b1;
    if (t > Q_MAX64) begin
      r.v = Q_MAX64[31:0];
    end else if (t < Q_MIN64) begin
      r.v = Q_MIN64[31:0];
    end else begin
      r.sat = 1'b0;
      r.v   = t[31:0];
    end
    return r;
  endfunction

  // Drop 16 fraction bits rounding toward zero, then saturate.
  function automatic sat32_t trunc_sat(input logic signed [63:0] p);
    logic [63:0]        mag;
    logic signed [63:0] t;
    mag = p[63] ? 64'(-p) : 64'(p);
    mag = mag >> 16;
    t   = p[63] ? -$signed(mag) : $signed(mag);
    return clamp32(t);
  endfunction

endpackage
`default_nettype wire

FILE: sv/pfa_front.sv
// Front end: takes requests, keeps the face table, classifies half-edges into jobs.
`default_nettype none
module pfa_front import pfa_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               req_type,
  input  wire logic [9:0]         face_index,
  input  wire logic [9:0]         pair_index,
  input  wire logic signed [31:0] vertex_x,
  input  wire logic signed [31:0] vertex_y,
  input  wire logic signed [31:0] end_x,
  input  wire logic signed [31:0] end_y,
  input  wire logic signed [31:0] value_a,
  input  wire logic signed [31:0] value_b,
  input  wire logic               face_outer,
  input  wire logic               pair_outer,
  input  wire logic               last_edge,
  output logic                    job_valid,
  output edge_job_t               job,
  input  wire logic               job_full
);

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_WRITE = 4'b0010,
    F_READ  = 4'b0100,
    F_PUSH  = 4'b1000
  } fstate_t;

  typedef struct packed {
    logic               en;
    logic signed [31:0] gamma;
    logic signed [31:0] lambda;
  } face_entry_t;

  fstate_t            state;
  logic               clearing;
  logic [FIDX_W-1:0]  clr_addr;
  face_entry_t        mem [FACE_COUNT];
  face_entry_t        rd_f, rd_p;

  logic               r_type, r_fo, r_po, r_last;
  logic [9:0]         r_fi, r_pi;
  logic signed [31:0] r_vx, r_vy, r_ex, r_ey, r_va, r_vb;

  logic               fi_ok, pi_ok, en1, en2;
  logic [FIDX_W-1:0]  fi_addr, pi_addr;
  logic signed [32:0] dx, dy;
  logic               accept;

  assign full    = clearing || (state != F_IDLE);
  assign accept  = push && !full;
  assign fi_ok   = 32'(r_fi) < 32'(FACE_COUNT);
  assign pi_ok   = 32'(r_pi) < 32'(FACE_COUNT);
  assign fi_addr = FIDX_W'(r_fi);
  assign pi_addr = FIDX_W'(r_pi);
  assign en1     = fi_ok && rd_f.en;
  assign en2     = pi_ok && rd_p.en;
  assign dx      = 33'(r_ex) - 33'(r_vx);
  assign dy      = 33'(r_ey) - 33'(r_vy);

  always_comb begin
    job_valid = (state == F_PUSH);
    job.active = (en1 || en2) && ((dx != '0) || (dy != '0));
    job.last   = r_last;
    job.dx     = dx;
    job.dy     = dy;
    job.g1     = (en1 && !r_fo) ? rd_f.gamma  : '0;
    job.l1     = (en1 && !r_fo) ? rd_f.lambda : '0;
    job.g2     = (en2 && !r_po) ? rd_p.gamma  : '0;
    job.l2     = (en2 && !r_po) ? rd_p.lambda : '0;
    job.p1     = r_va;
    job.p2     = r_vb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      clearing <= 1'b1;
      clr_addr <= '0;
    end else begin
      if (clearing && (clr_addr == FIDX_W'(FACE_COUNT - 1))) begin
        clearing <= 1'b0;
      end
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
      end
      case (state)
        F_IDLE: begin
          if (accept) begin
            state <= req_type ? F_READ : F_WRITE;
          end
        end
        F_WRITE: state <= F_IDLE;
        F_READ:  state <= F_PUSH;
        F_PUSH: begin
          if (!job_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_type <= req_type;
      r_fi   <= face_index;
      r_pi   <= pair_index;
      r_vx   <= vertex_x;
      r_vy   <= vertex_y;
      r_ex   <= end_x;
      r_ey   <= end_y;
      r_va   <= value_a;
      r_vb   <= value_b;
      r_fo   <= face_outer;
      r_po   <= pair_outer;
      r_last <= last_edge;
    end
  end

  // face table: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if ((state == F_WRITE) && !r_type && fi_ok) begin
      mem[fi_addr] <= {1'b1, r_va, r_vb};
    end
    rd_f <= mem[fi_addr];
    rd_p <= mem[pi_addr];
  end

endmodule
`default_nettype wire

FILE: sv/pfa_queue.sv
// Short job queue between the front end and the back end.
`default_nettype none
module pfa_queue import pfa_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      wr_valid,
  input  edge_job_t      wr_data,
  output logic           wr_full,
  output logic           rd_valid,
  output edge_job_t      rd_data,
  input  wire logic      rd_pop
);

  edge_job_t         slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_wr, do_rd;

  assign wr_full  = (count == (QPTR_W+1)'(QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_valid && !wr_full;
  assign do_rd    = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

endmodule
`default_nettype wire

FILE: sv/pfa_back.sv
// Back end: normalizes the edge, serial square root and divide, force accumulation.
`default_nettype none
`include "perimeter_force_accumulator_defines.svh"
module pfa_back import pfa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  edge_job_t q_data,
  output logic      q_pop,
  input  wire logic out_full,
  output logic      res_valid,
  output result_t   res
);

  typedef enum logic [9:0] {
    B_IDLE = 10'b0000000001,
    B_NORM = 10'b0000000010,
    B_SQX  = 10'b0000000100,
    B_SQY  = 10'b0000001000,
    B_ROOT = 10'b0000010000,
    B_DIV  = 10'b0000100000,
    B_COEF = 10'b0001000000,
    B_MUL  = 10'b0010000000,
    B_ACC  = 10'b0100000000,
    B_EMIT = 10'b1000000000
  } bstate_t;

  localparam logic signed [48:0] ACC_MAX = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [48:0] ACC_MIN = 49'sh1_8000_0000_0000;

  bstate_t            state;
  edge_job_t          job;
  logic [31:0]        ax, ay;
  logic [63:0]        sq, rn, root, rbit;
  logic [4:0]         cnt;
  logic [33:0]        rx, ry;
  logic [16:0]        qx, qy;
  logic signed [63:0] prod;
  logic signed [31:0] t1, t2, coef;
  logic signed [49:0] px, py;
  logic signed [47:0] sum_x, sum_y;
  logic               sat_seen;

  logic [32:0]        adx, ady;
  logic               big;
  logic [31:0]        aor;
  logic [63:0]        rtry;
  logic [33:0]        len34;
  logic               bx, by;
  sat32_t             ts, cs, cx, cy, fx, fy;
  logic signed [35:0] csum;
  logic signed [17:0] ux, uy;
  logic signed [48:0] nx, ny;

  function automatic logic signed [47:0] clamp48(input logic signed [48:0] v);
    if (v > ACC_MAX) return ACC_MAX[47:0];
    if (v < ACC_MIN) return ACC_MIN[47:0];
    return v[47:0];
  endfunction

  assign adx   = q_data.dx[32] ? 33'(-q_data.dx) : 33'(q_data.dx);
  assign ady   = q_data.dy[32] ? 33'(-q_data.dy) : 33'(q_data.dy);
  assign big   = adx[31] | ady[31];
  assign aor   = ax | ay;
  assign rtry  = root + rbit;
  assign len34 = {2'b00, root[31:0]};
  assign bx    = rx >= len34;
  assign by    = ry >= len34;
  assign ts    = trunc_sat(prod);
  assign csum  = 36'(t1) + 36'(t2) - 36'(job.l1) - 36'(job.l2);
  assign cs    = clamp32(64'(csum));
  assign ux    = job.dx[32] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign uy    = job.dy[32] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
  assign cx    = trunc_sat(64'(px));
  assign cy    = trunc_sat(64'(py));
  assign nx    = 49'(sum_x) + 49'(cx.v);
  assign ny    = 49'(sum_y) + 49'(cy.v);
  assign fx    = clamp32(64'(sum_x));
  assign fy    = clamp32(64'(sum_y));

  assign q_pop     = (state == B_IDLE) && q_valid;
  assign res_valid = (state == B_EMIT) && !out_full;
  assign res.fx    = fx.v;
  assign res.fy    = fy.v;
  assign res.sat   = sat_seen | fx.sat | fy.sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      sum_x    <= '0;
      sum_y    <= '0;
      sat_seen <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            job <= q_data;
            ax  <= big ? adx[32:1] : adx[31:0];
            ay  <= big ? ady[32:1] : ady[31:0];
            if (q_data.active) state <= B_NORM;
            else if (q_data.last) state <= B_EMIT;
          end
        end
        B_NORM: begin
          // larger magnitude must reach bit 30
          if (aor[30]) begin
            state <= B_SQX;
          end else if (aor[30:23] == '0) begin
            ax <= ax << 8;
            ay <= ay << 8;
          end else begin
            ax <= ax << 1;
            ay <= ay << 1;
          end
        end
        B_SQX: begin
          sq    <= 64'(ax) * 64'(ax);
          state <= B_SQY;
        end
        B_SQY: begin
          rn    <= sq + 64'(ay) * 64'(ay);
          root  <= '0;
          rbit  <= 64'h4000_0000_0000_0000;
          cnt   <= '0;
          state <= B_ROOT;
        end
        B_ROOT: begin
          if (rn >= rtry) begin
            rn   <= rn - rtry;
            root <= (root >> 1) + rbit;
          end else begin
            root <= root >> 1;
          end
          rbit <= rbit >> 2;
          cnt  <= cnt + 1'b1;
          if (cnt == 5'd31) begin
            rx    <= {2'b00, ax};
            ry    <= {2'b00, ay};
            qx    <= '0;
            qy    <= '0;
            cnt   <= '0;
            state <= B_DIV;
          end
        end
        B_DIV: begin
          rx  <= (bx ? rx - len34 : rx) << 1;
          ry  <= (by ? ry - len34 : ry) << 1;
          qx  <= {qx[15:0], bx};
          qy  <= {qy[15:0], by};
          cnt <= cnt + 1'b1;
          if (cnt == 5'd16) begin
            cnt   <= '0;
            state <= B_COEF;
          end
        end
        B_COEF: begin
          cnt <= cnt + 1'b1;
          case (cnt[1:0])
            2'd0: prod <= job.g1 * job.p1;
            2'd1: begin
              t1       <= ts.v;
              sat_seen <= sat_seen | ts.sat;
              prod     <= job.g2 * job.p2;
            end
            2'd2: begin
              t2       <= ts.v;
              sat_seen <= sat_seen | ts.sat;
            end
            default: begin
              coef     <= cs.v;
              sat_seen <= sat_seen | cs.sat;
              state    <= B_MUL;
            end
          endcase
        end
        B_MUL: begin
          px    <= coef * ux;
          py    <= coef * uy;
          state <= B_ACC;
        end
        B_ACC: begin
          sum_x    <= clamp48(nx);
          sum_y    <= clamp48(ny);
          sat_seen <= sat_seen | cx.sat | cy.sat | (nx > ACC_MAX) | (nx < ACC_MIN)
                      | (ny > ACC_MAX) | (ny < ACC_MIN);
          state    <= job.last ? B_EMIT : B_IDLE;
        end
        B_EMIT: begin
          if (!out_full) begin
            sum_x    <= '0;
            sum_y    <= '0;
            sat_seen <= 1'b0;
            state    <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  `PFA_ASSERT_IMP(a_len_norm, state == B_DIV, root[31:30] != 2'b00, "edge length not normalized")
  `PFA_ASSERT_IMP(a_rem_bound, state == B_DIV, rx < (len34 << 1), "divider remainder out of range")
  `PFA_ASSERT_NXT(a_emit_clear, res_valid, (sum_x == '0) && (sum_y == '0) && !sat_seen,
                  "accumulator not cleared after result")

endmodule
`default_nettype wire

FILE: sv/perimeter_force_accumulator.sv
// Half-edge request: after acceptance the front end reads the face table and offers the job until
// the queue takes it; the back end then pops, normalizes, squares, takes the serial root, runs the
// two-lane divide, makes the coefficient, multiplies and accumulates, then takes the next job.
// A set request only writes the face table. A result is registered into the output register on emit.
// After rst the face table is cleared one entry a cycle; full stays high until every entry is cleared.
// rst is synchronous, active high; it empties the job queue, the output register and the accumulator.
`default_nettype none
module perimeter_force_accumulator import pfa_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               req_type,
  input  wire logic [9:0]         face_index,
  input  wire logic [9:0]         pair_index,
  input  wire logic signed [31:0] vertex_x,
  input  wire logic signed [31:0] vertex_y,
  input  wire logic signed [31:0] end_x,
  input  wire logic signed [31:0] end_y,
  input  wire logic signed [31:0] value_a,
  input  wire logic signed [31:0] value_b,
  input  wire logic               face_outer,
  input  wire logic               pair_outer,
  input  wire logic               last_edge,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [31:0]      force_x,
  output logic signed [31:0]      force_y,
  output logic                    saturated
);

  edge_job_t f_job, q_job;
  logic      f_valid, f_full, q_valid, q_pop;
  logic      res_valid, out_valid;
  result_t   res, out_res;

  pfa_front u_front (
    .clk, .rst, .push, .full, .req_type, .face_index, .pair_index,
    .vertex_x, .vertex_y, .end_x, .end_y, .value_a, .value_b,
    .face_outer, .pair_outer, .last_edge,
    .job_valid (f_valid),
    .job       (f_job),
    .job_full  (f_full)
  );

  pfa_queue u_queue (
    .clk, .rst,
    .wr_valid (f_valid),
    .wr_data  (f_job),
    .wr_full  (f_full),
    .rd_valid (q_valid),
    .rd_data  (q_job),
    .rd_pop   (q_pop)
  );

  pfa_back u_back (
    .clk, .rst,
    .q_valid   (q_valid),
    .q_data    (q_job),
    .q_pop     (q_pop),
    .out_full  (out_valid),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) out_res <= res;
  end

  assign empty     = !out_valid;
  assign force_x   = out_res.fx;
  assign force_y   = out_res.fy;
  assign saturated = out_res.sat;

endmodule
`default_nettype wire
